/* src/fpvn_pkg.sv */
// Shared types and constants for the fixed-point 3-vector normalizer.
`default_nettype none
package fpvn_pkg;

	localparam int COMP_W           = 16;
	localparam int MUL_W            = 24;
	localparam int FRAC_BITS        = 8;
	localparam int NEWTON_STEPS_DEF = 8;

	localparam logic [COMP_W-1:0] X_INIT       = 16'h0100;
	localparam logic [16:0]       THREE_HALVES = 17'h00180;
	localparam logic signed [COMP_W-1:0] MAG_MAX = 16'sd255;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_SQ,
		ST_NEWT,
		ST_SCALE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQ_Z,
		OP_XX,
		OP_AT,
		OP_DX,
		OP_SC_X,
		OP_SC_Y,
		OP_SC_Z
	} mul_op_t;

	typedef struct packed {
		logic    ready;
		logic    load;
		logic    halve;
		mul_op_t op;
		logic    sum_clr;
		logic    sum_acc;
		logic    x_init;
		logic    x_ld;
		logic    rx_ld;
		logic    ry_ld;
		logic    out_ld;
	} ctrl_t;

endpackage
`default_nettype wire

/* src/fpvn_mul.sv */
// Shared multiplier: low 24 bits of a 24x24 product, registered.
`default_nettype none
module fpvn_mul (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [fpvn_pkg::MUL_W-1:0] a,
	input  wire logic [fpvn_pkg::MUL_W-1:0] b,
	output logic      [fpvn_pkg::MUL_W-1:0] p
);

	// only the low 24 bits of the product are ever needed
	logic [fpvn_pkg::MUL_W-1:0] full;
	logic [fpvn_pkg::MUL_W-1:0] p_q;

	assign full = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= full;
		end
	end

	assign p = p_q;

endmodule
`default_nettype wire

/* src/fpvn_seq.sv */
// Sequencer that schedules prescaling, squares, Newton steps and scaling.
`default_nettype none
module fpvn_seq #(
	parameter int NEWTON_STEPS = fpvn_pkg::NEWTON_STEPS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            need_halve,
	input  wire logic            out_free,
	output fpvn_pkg::ctrl_t      ctrl
);

	localparam int STEP_W = $clog2(NEWTON_STEPS + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NEWTON_STEPS - 1);

	fpvn_pkg::state_t state_q, state_d;
	logic [1:0]        ph_q, ph_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpvn_pkg::ST_IDLE;
			ph_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		cnt_d   = cnt_q;
		ctrl    = '0;
		ctrl.op = fpvn_pkg::OP_NONE;
		unique case (state_q)
			fpvn_pkg::ST_IDLE: begin
				ctrl.ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = fpvn_pkg::ST_PRE;
				end
			end
			fpvn_pkg::ST_PRE: begin
				if (need_halve) begin
					ctrl.halve = 1'b1;
				end else begin
					state_d = fpvn_pkg::ST_SQ;
					ph_d    = 2'd0;
				end
			end
			fpvn_pkg::ST_SQ: begin
				ph_d = ph_q + 2'd1;
				unique case (ph_q)
					2'd0: ctrl.op = fpvn_pkg::OP_SQ_X;
					2'd1: begin
						ctrl.op      = fpvn_pkg::OP_SQ_Y;
						ctrl.sum_clr = 1'b1;
					end
					2'd2: begin
						ctrl.op      = fpvn_pkg::OP_SQ_Z;
						ctrl.sum_acc = 1'b1;
					end
					default: begin
						ctrl.sum_acc = 1'b1;
						state_d      = fpvn_pkg::ST_NEWT;
						ph_d         = 2'd0;
						cnt_d        = '0;
					end
				endcase
			end
			fpvn_pkg::ST_NEWT: begin
				unique case (ph_q)
					2'd0: begin
						ctrl.op     = fpvn_pkg::OP_XX;
						ctrl.x_ld   = 1'b1;
						ctrl.x_init = (cnt_q == '0);
						ph_d        = 2'd1;
					end
					2'd1: begin
						ctrl.op = fpvn_pkg::OP_AT;
						ph_d    = 2'd2;
					end
					default: begin
						ctrl.op = fpvn_pkg::OP_DX;
						ph_d    = 2'd0;
						if (cnt_q == LAST_STEP) begin
							state_d = fpvn_pkg::ST_SCALE;
						end else begin
							cnt_d = cnt_q + 1'b1;
						end
					end
				endcase
			end
			fpvn_pkg::ST_SCALE: begin
				unique case (ph_q)
					2'd0: begin
						ctrl.op   = fpvn_pkg::OP_SC_X;
						ctrl.x_ld = 1'b1;
						ph_d      = 2'd1;
					end
					2'd1: begin
						ctrl.op    = fpvn_pkg::OP_SC_Y;
						ctrl.rx_ld = 1'b1;
						ph_d       = 2'd2;
					end
					2'd2: begin
						ctrl.op    = fpvn_pkg::OP_SC_Z;
						ctrl.ry_ld = 1'b1;
						ph_d       = 2'd3;
					end
					default: begin
						// hold here while the previous result is still unclaimed
						if (out_free) begin
							ctrl.out_ld = 1'b1;
							state_d     = fpvn_pkg::ST_IDLE;
							ph_d        = 2'd0;
						end
					end
				endcase
			end
			default: begin
				state_d = fpvn_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/fixed_point_vec3_normalize.sv */
// Top level of the fixed-point 3-vector normalizer.
`default_nettype none
// Normalizes a signed 16-bit 3-vector to about unit length, 256 meaning one.
// One item is in work at a time: s_axis_tready is high only while the block
// is idle, and a finished result sits in the output register until taken,
// so the next vector can be accepted meanwhile. The time from one accept to
// the next grows with NEWTON_STEPS (8 by default) and with h (0..8), the number
// of halvings needed to bring every magnitude below 256. It is set by the single
// shared 24x24 multiplier: three squares, three products per Newton step and
// three output scalings, one product per cycle. Products wrap to 24 bits and
// are never saturated; a zero vector yields zero.
module fixed_point_vec3_normalize #(
	parameter int NEWTON_STEPS = fpvn_pkg::NEWTON_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // in_x[15:0], in_y[31:16], in_z[47:32]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata   // out_x[15:0], out_y[31:16], out_z[47:32]
);

	localparam int MW = fpvn_pkg::MUL_W;
	localparam int FB = fpvn_pkg::FRAC_BITS;

	fpvn_pkg::ctrl_t ctrl;

	logic signed [15:0] vx_q, vy_q, vz_q;
	logic [MW-1:0]      sum_q;
	logic [15:0]        x_q;
	logic [15:0]        rx_q, ry_q;
	logic [15:0]        ox_q, oy_q, oz_q;
	logic               out_valid_q;

	logic [MW-1:0] p;
	logic [MW-1:0] op_a, op_b;
	logic [15:0]   p_hi;
	logic [15:0]   cur_x;
	logic [14:0]   t_half;
	logic [16:0]   diff;
	logic          need_halve;
	logic          out_free;

	function automatic logic signed [15:0] halve_tz(input logic signed [15:0] v);
		logic [16:0] tmp;
		tmp = {v[15], v} + {16'b0, v[15]};
		return $signed(tmp[16:1]);
	endfunction

	function automatic logic is_big(input logic signed [15:0] v);
		return (v > fpvn_pkg::MAG_MAX) || (v < -fpvn_pkg::MAG_MAX);
	endfunction

	function automatic logic [MW-1:0] sext(input logic [15:0] v);
		return {{(MW-16){v[15]}}, v};
	endfunction

	assign need_halve = is_big(vx_q) || is_big(vy_q) || is_big(vz_q);
	assign out_free   = !out_valid_q || m_axis_tready;

	fpvn_seq #(
		.NEWTON_STEPS(NEWTON_STEPS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.need_halve(need_halve),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	assign p_hi   = p[MW-1:FB];
	assign cur_x  = ctrl.x_init ? fpvn_pkg::X_INIT : p_hi;
	assign t_half = p_hi[15:1];
	// 0x180 - t_half as a 17-bit two's complement value
	assign diff   = fpvn_pkg::THREE_HALVES - {2'b00, t_half};

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (ctrl.op)
			fpvn_pkg::OP_SQ_X: begin
				op_a = sext(vx_q);
				op_b = sext(vx_q);
			end
			fpvn_pkg::OP_SQ_Y: begin
				op_a = sext(vy_q);
				op_b = sext(vy_q);
			end
			fpvn_pkg::OP_SQ_Z: begin
				op_a = sext(vz_q);
				op_b = sext(vz_q);
			end
			fpvn_pkg::OP_XX: begin
				op_a = {{(MW-16){1'b0}}, cur_x};
				op_b = {{(MW-16){1'b0}}, cur_x};
			end
			fpvn_pkg::OP_AT: begin
				op_a = {{(MW-16){1'b0}}, sum_q[MW-1:FB]};
				op_b = {{(MW-16){1'b0}}, p_hi};
			end
			fpvn_pkg::OP_DX: begin
				op_a = {{(MW-17){diff[16]}}, diff};
				op_b = {{(MW-16){1'b0}}, x_q};
			end
			fpvn_pkg::OP_SC_X: begin
				op_a = sext(vx_q);
				op_b = {{(MW-16){1'b0}}, cur_x};
			end
			fpvn_pkg::OP_SC_Y: begin
				op_a = sext(vy_q);
				op_b = {{(MW-16){1'b0}}, x_q};
			end
			fpvn_pkg::OP_SC_Z: begin
				op_a = sext(vz_q);
				op_b = {{(MW-16){1'b0}}, x_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	fpvn_mul u_mul (
		.clk(clk),
		.en (ctrl.op != fpvn_pkg::OP_NONE),
		.a  (op_a),
		.b  (op_b),
		.p  (p)
	);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			vx_q <= $signed(s_axis_tdata[15:0]);
			vy_q <= $signed(s_axis_tdata[31:16]);
			vz_q <= $signed(s_axis_tdata[47:32]);
		end else if (ctrl.halve) begin
			vx_q <= halve_tz(vx_q);
			vy_q <= halve_tz(vy_q);
			vz_q <= halve_tz(vz_q);
		end
		if (ctrl.sum_clr) begin
			sum_q <= p;
		end else if (ctrl.sum_acc) begin
			sum_q <= sum_q + p;
		end
		if (ctrl.x_ld) begin
			x_q <= cur_x;
		end
		if (ctrl.rx_ld) begin
			rx_q <= p_hi;
		end
		if (ctrl.ry_ld) begin
			ry_q <= p_hi;
		end
		if (ctrl.out_ld) begin
			ox_q <= rx_q;
			oy_q <= ry_q;
			oz_q <= p_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_axis_tready = ctrl.ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {oz_q, oy_q, ox_q};

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the fixed-point 3-vector normalizer.
`timescale 1ns / 100ps

module testbench;

	localparam int NEWTON_STEPS = fpvn_pkg::NEWTON_STEPS_DEF;
	localparam int IDLE_LIMIT   = 3000;  // cycles with no transfer on either side
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 64;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // in_x[15:0], in_y[31:16], in_z[47:32]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // out_x[15:0], out_y[31:16], out_z[47:32]

	logic [47:0] pending_norm [$];
	logic [47:0] want;
	string       field_name [3] = '{"out_x", "out_y", "out_z"};
	int          errors      = 0;
	int          n_sent      = 0;
	int          n_checked   = 0;
	int          idle_cycles = 0;
	int          burst_left  = 0;
	bit          hold_req    = 1'b0;

	fixed_point_vec3_normalize #(
		.NEWTON_STEPS(NEWTON_STEPS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Halve toward zero until all magnitudes < 256, then scale by the wrapped
	// Newton inverse square root of the squared length.
	function automatic logic [47:0] normalize_vec(logic [47:0] raw);
		int          c [3];
		logic [31:0] sum;
		logic [31:0] prod;
		logic [31:0] diff;
		logic [31:0] cu;
		logic [15:0] a;
		logic [15:0] x;
		logic [15:0] t;
		logic [47:0] res;
		for (int i = 0; i < 3; i++)
			c[i] = int'($signed(raw[16*i +: 16]));
		while (c[0] >= 256 || c[0] <= -256 || c[1] >= 256 || c[1] <= -256 ||
				c[2] >= 256 || c[2] <= -256) begin
			for (int i = 0; i < 3; i++)
				c[i] = c[i] / 2;
		end
		sum = '0;
		for (int i = 0; i < 3; i++)
			sum = sum + c[i] * c[i];
		a = sum[fpvn_pkg::FRAC_BITS +: fpvn_pkg::COMP_W];
		x = fpvn_pkg::X_INIT;
		repeat (NEWTON_STEPS) begin
			prod = {16'd0, x} * {16'd0, x};
			t    = prod[fpvn_pkg::FRAC_BITS +: fpvn_pkg::COMP_W];
			prod = {16'd0, a} * {16'd0, t};
			t    = prod[fpvn_pkg::FRAC_BITS +: fpvn_pkg::COMP_W] >> 1;
			diff = 32'(fpvn_pkg::THREE_HALVES) - {16'd0, t};
			prod = diff * {16'd0, x};
			x    = prod[fpvn_pkg::FRAC_BITS +: fpvn_pkg::COMP_W];
		end
		for (int i = 0; i < 3; i++) begin
			cu   = c[i];
			prod = cu * {16'd0, x};
			res[16*i +: 16] = prod[fpvn_pkg::FRAC_BITS +: fpvn_pkg::COMP_W];
		end
		return res;
	endfunction

	function automatic logic [47:0] vec(int x, int y, int z);
		logic [15:0] x16, y16, z16;
		x16 = x[15:0];
		y16 = y[15:0];
		z16 = z[15:0];
		return {z16, y16, x16};
	endfunction

	function automatic int pick_comp();
		int sign;
		sign = $urandom_range(0, 1) ? -1 : 1;
		case ($urandom_range(0, 5))
			0, 1:    return int'($urandom_range(0, 65534)) - 32767;
			2:       return int'($urandom_range(0, 510)) - 255;
			3:       return sign * int'($urandom_range(250, 262));
			4:       return sign * int'($urandom_range(32000, 32767));
			default: return int'($urandom_range(0, 8)) - 4;
		endcase
	endfunction

	function automatic logic [47:0] rand_vec();
		return vec(pick_comp(), pick_comp(), pick_comp());
	endfunction

	// Called and returning just after a falling edge.
	task automatic send_vec(input logic [47:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 48);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_axis_tdata  <= v;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_norm.push_back(normalize_vec(v));
		n_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_norm.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_extremes();
		logic [47:0] dir [$];
		dir = '{vec(0, 0, 0), vec(32767, 32767, 32767), vec(-32767, -32767, -32767),
			vec(-32768, 0, 0), vec(-32768, -32768, -32768), vec(32767, 0, 0),
			vec(0, -32767, 0), vec(0, 0, 32767), vec(255, 0, 0), vec(256, 0, 0),
			vec(-255, 0, 0), vec(-256, 0, 0), vec(1, 0, 0), vec(-1, -1, -1),
			vec(255, 255, 255), vec(-255, 255, -255), vec(16'h5555, 16'h2aaa, 16'h5555),
			vec(-21846, 21845, -21846), vec(128, 0, 0), vec(0, 181, 181)};
		foreach (dir[i])
			send_vec(dir[i]);
	endtask

	task automatic test_random_mix(input int count);
		repeat (count)
			send_vec(rand_vec());
	endtask

	// Output stalls for a long stretch while the input keeps offering vectors.
	task automatic test_output_backpressure();
		hold_req   = 1'b1;
		burst_left = 1000;
		repeat (40)
			send_vec(rand_vec());
		burst_left = 0;
	endtask

	task automatic test_drain_pause();
		repeat (30)
			send_vec(rand_vec());
		wait_drained();
		repeat (30)
			send_vec(rand_vec());
	endtask

	// Receiver: random stall patterns, plus one long hold on request.
	initial begin
		int       run;
		int       phase;
		rx_mode_t mode;
		m_axis_tready = 1'b0;
		run   = 0;
		phase = 0;
		mode  = RX_FREE;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (run == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					run  = $urandom_range(20, 200);
				end
				run--;
				phase++;
				case (mode)
					RX_FREE:   m_axis_tready <= 1'b1;
					RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default:   m_axis_tready <= (phase % 7) < 3;
				endcase
			end
		end
	end

	// Result checker: each output transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_norm.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_norm.pop_front();
				for (int f = 0; f < 3; f++) begin
					if (want[16*f +: 16] !== m_axis_tdata[16*f +: 16]) begin
						$error("%s: expected %0d, actual %0d", field_name[f],
							$signed(want[16*f +: 16]), $signed(m_axis_tdata[16*f +: 16]));
						errors++;
					end
				end
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending_norm.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_random_mix(700);
		test_output_backpressure();
		test_drain_pause();
		test_random_mix(700);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_norm.size() != 0) begin
			$error("%0d results never arrived", pending_norm.size());
			errors++;
		end
		$display("summary: %0d vectors in, %0d results compared, %0d mismatches",
			n_sent, n_checked, errors);
		$display("summary: extremes, halving boundaries, long output hold, drain pause");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
